>>> hdl/assert_macros.svh
// Assertion macros shared by the sender window RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GBN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression must never be true out of reset
`define GBN_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

>>> hdl/gbn_pkg.sv
// Package for the Go-Back-N sender window: codes, defaults, state type and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gbn_pkg;

	localparam int MAX_WINDOW_DEF = 16;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int SEQ_W          = 32;
	localparam int TICK_W         = 16;
	localparam int WSIZE_W        = 5;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_ACK    = 2'd1;
	localparam logic [1:0] FUNC_START  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_FIN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

	localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST   = 5'd4;
	localparam logic [SEQ_W-1:0]   TOTAL_PACKETS_RST = 32'd0;
	localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 16'd1000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CALC,
		S_FIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic calc;
		logic load_fin;
		logic load_data;
	} dp_cmd_t;

	typedef struct packed {
		logic ignore;
		logic done;
		logic n_zero;
		logic last_one;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/gbn_datapath.sv
// Datapath of the sender window: config registers, window state, burst
// counter and output register. Depends on gbn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gbn_datapath #(
	parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [1:0]                         func,
	input  wire logic [gbn_pkg::SEQ_W-1:0]          ack_number,
	input  wire logic                               ack_good,
	input  wire logic                               out_stall,
	input  wire gbn_pkg::dp_cmd_t                   cmd,
	output gbn_pkg::dp_sts_t                        sts,
	output logic                                    out_valid,
	output logic                                    command,
	output logic [gbn_pkg::SEQ_W-1:0]               sequence_res,
	output logic                                    last
);
	import gbn_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	logic [WSIZE_W-1:0] win_size_q;
	logic [SEQ_W-1:0]   total_q;
	logic [TICK_W-1:0]  tmo_q;

	logic [1:0]         func_q;
	logic [SEQ_W-1:0]   ack_q;
	logic               good_q;

	logic [SEQ_W-1:0]   base_q, base_d;
	logic [SEQ_W-1:0]   next_q, next_d;
	logic [TICK_W-1:0]  idle_q, idle_d;
	logic               active_q, active_d;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic               command_q;
	logic [SEQ_W-1:0]   seq_q;
	logic               last_q;

	logic [TICK_W-1:0]  limit;
	logic [TICK_W-1:0]  idle_inc;
	logic [SEQ_W:0]     nb;
	logic [SEQ_W-1:0]   win_w, gap, rem_win, rem_tot, n_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= WINDOW_SIZE_RST;
			total_q    <= TOTAL_PACKETS_RST;
			tmo_q      <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SIZE:   win_size_q <= cfg_data[WSIZE_W-1:0];
				REG_TOTAL_PACKETS: total_q    <= cfg_data[SEQ_W-1:0];
				REG_TIMEOUT_TICKS: tmo_q      <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			ack_q  <= ack_number;
			good_q <= ack_good;
		end
	end

	always_comb begin
		limit    = (tmo_q == '0) ? TICK_W'(1) : tmo_q;
		idle_inc = (idle_q == '1) ? idle_q : idle_q + TICK_W'(1);
		nb       = {1'b0, ack_q} + (SEQ_W+1)'(1);
		base_d   = base_q;
		next_d   = next_q;
		idle_d   = idle_q;
		active_d = active_q;
		if (cmd.update) begin
			case (func_q)
				FUNC_START: begin
					base_d   = '0;
					next_d   = '0;
					idle_d   = '0;
					active_d = 1'b1;
				end
				FUNC_ACK: begin
					if (good_q) begin
						if (ack_q >= base_q)
							base_d = (nb > {1'b0, next_q}) ? next_q : nb[SEQ_W-1:0];
						idle_d = '0;
					end
				end
				FUNC_TICK: begin
					if (idle_inc >= limit) begin
						next_d = base_q;
						idle_d = '0;
					end else begin
						idle_d = idle_inc;
					end
				end
				default: ;
			endcase
		end
		if (cmd.load_fin)
			active_d = 1'b0;
		if (cmd.load_data)
			next_d = next_q + SEQ_W'(1);
	end

	// packets still allowed out: limited by window space and by the transfer end
	always_comb begin
		win_w = (win_size_q == '0) ? SEQ_W'(1) : SEQ_W'(win_size_q);
		if (win_w > SEQ_W'(MAX_WINDOW))
			win_w = SEQ_W'(MAX_WINDOW);
		gap     = next_q - base_q;
		rem_win = (gap < win_w) ? win_w - gap : '0;
		rem_tot = (total_q > next_q) ? total_q - next_q : '0;
		n_val   = (rem_win < rem_tot) ? rem_win : rem_tot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			next_q   <= '0;
			idle_q   <= '0;
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			base_q   <= base_d;
			next_q   <= next_d;
			idle_q   <= idle_d;
			active_q <= active_d;
			if (cmd.calc)
				cnt_q <= n_val[CNT_W-1:0];
			else if (cmd.load_data)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_fin || cmd.load_data)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fin) begin
			command_q <= CMD_FIN;
			seq_q     <= next_q;
			last_q    <= 1'b1;
		end else if (cmd.load_data) begin
			command_q <= CMD_DATA;
			seq_q     <= next_q;
			last_q    <= (cnt_q == CNT_W'(1));
		end
	end

	always_comb begin
		sts.ignore   = (func_q == FUNC_UNUSED) || (func_q != FUNC_START && !active_q);
		sts.done     = (base_q >= total_q);
		sts.n_zero   = (n_val == '0);
		sts.last_one = (cnt_q == CNT_W'(1));
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid    = out_valid_q;
	assign command      = command_q;
	assign sequence_res = seq_q;
	assign last         = last_q;

	`GBN_ASSERT(a_base_le_next, next_q >= base_q, "window base passed next sequence")
	`GBN_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_WINDOW), "burst count above window limit")
	`GBN_ASSERT(a_load_free, (cmd.load_fin || cmd.load_data) |-> sts.out_free, "output overwritten")
	`GBN_NEVER(a_load_both, cmd.load_fin && cmd.load_data, "FIN and data loaded together")

endmodule

`default_nettype wire

>>> hdl/gbn_ctrl.sv
// Controller of the sender window: sequences evaluate, count and emit steps.
// Depends on gbn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gbn_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire gbn_pkg::dp_sts_t    sts,
	output gbn_pkg::dp_cmd_t         cmd,
	output logic                     in_stall
);
	import gbn_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = sts.ignore ? S_IDLE : S_CALC;
			end
			S_CALC: begin
				if (sts.done)
					state_d = S_FIN;
				else if (sts.n_zero)
					state_d = S_IDLE;
				else
					state_d = S_EMIT;
			end
			S_FIN: begin
				if (sts.out_free)
					state_d = S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free && sts.last_one)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_EVAL:  cmd.update    = !sts.ignore;
			S_CALC:  cmd.calc      = !sts.done;
			S_FIN:   cmd.load_fin  = sts.out_free;
			S_EMIT:  cmd.load_data = sts.out_free;
			default: ;
		endcase
	end

	`GBN_ASSERT(a_fin_exit, (state_q == S_FIN && sts.out_free) |=> (state_q == S_IDLE), "FIN not final")
	`GBN_ASSERT(a_take_only_idle, cmd.capture |-> (state_q == S_IDLE), "item taken while busy")

endmodule

`default_nettype wire

>>> hdl/go_back_n_sender_window.sv
// Top level of the Go-Back-N sender window: controller plus datapath.
// Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  in       | in_valid / in_stall  | func, ack_number, ack_good
//  out      | out_valid / out_stall| command, sequence_res, last
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// An item is evaluated in EVAL, its burst (up to MAX_WINDOW commands) sized
// in CALC; results then leave the single output register, one per cycle
// while not stalled. Ignored items end in EVAL, empty bursts in CALC.
// Output stalls hold the burst; in_stall stays high until the last result is
// loaded. arst_n clears the window state and loads register defaults.
`default_nettype none

module go_back_n_sender_window #(
	parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         func,
	input  wire logic [gbn_pkg::SEQ_W-1:0]          ack_number,
	input  wire logic                               ack_good,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    command,
	output logic [gbn_pkg::SEQ_W-1:0]               sequence_res,
	output logic                                    last
);
	import gbn_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	gbn_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.ack_number   (ack_number),
		.ack_good     (ack_good),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.command      (command),
		.sequence_res (sequence_res),
		.last         (last)
	);

endmodule

`default_nettype wire
